@@ rtl/nearest_neighbor_row_scaler_macros.svh @@
// Assertion macros shared by the checker of the nearest-neighbor row scaler.
`ifndef NEAREST_NEIGHBOR_ROW_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_ROW_SCALER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define NNRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define NNRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nnrs_pkg.sv @@
// Shared types, constants and helpers of the nearest-neighbor row scaler.
package nnrs_pkg;

    localparam int MAX_DST_COLS_DEF = 4096;
    localparam int MAX_ZOOM_DEF     = 64;

    // Width of signed results of the shared arithmetic unit.
    localparam int RW = 52;
    // Width of operand magnitudes.
    localparam int AW = 50;
    // Width of divisors and remainders.
    localparam int DW = 17;
    localparam int CNTW = 6;
    localparam logic [CNTW-1:0] DIV_STEPS = 6'd50;
    localparam logic [CNTW-1:0] MUL_STEPS = 6'd16;

    typedef enum logic [2:0] {
        CFG_SRC_COL_START,
        CFG_SRC_COL_END,
        CFG_SRC_ROW_START,
        CFG_SRC_ROW_END,
        CFG_DST_COL_START,
        CFG_DST_COL_END,
        CFG_DST_ROW_START,
        CFG_DST_ROW_END
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OP_K0,
        OP_K1,
        OP_MULT,
        OP_TDIV,
        OP_C0,
        OP_CI
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_R_MUL,
        S_K0,
        S_K1,
        S_MULT,
        S_TDIV,
        S_R_FIN,
        S_C0,
        S_CI,
        S_C_INIT,
        S_SKIP,
        S_EMIT,
        S_END
    } t_state;

    typedef struct packed {
        logic load_in;
        logic new_row;
        logic mul_row;
        logic arith_go;
        t_op  op;
        logic row_fin;
        logic col_init;
        logic advance;
        logic push;
        logic flush;
        logic special;
    } t_cmd;

    typedef struct packed {
        logic arith_done;
        logic rows_ok;
        logic cols_ok;
        logic col_lt;
        logic src_lt;
        logic src_eq;
        logic height_nz;
        logic pend_valid;
        logic out_free;
        logic last;
    } t_status;

    function automatic logic signed [RW-1:0] sx17(input logic signed [16:0] v);
        return {{(RW-17){v[16]}}, v};
    endfunction

endpackage

@@ rtl/nnrs_arith.sv @@
// Shared serial unit: restoring divider with floor or ceiling rounding and shift-add multiplier.
module nnrs_arith import nnrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic                 i_mul,
    input  logic                 i_ceil,
    input  logic signed [RW-1:0] i_a,
    input  logic [DW-1:0]        i_b,
    output logic                 o_done,
    output logic signed [RW-1:0] o_res,
    output logic [DW-1:0]        o_rem
);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic            r_mul;
    logic            r_ceil;
    logic            r_neg;
    logic [AW-1:0]   r_q;
    logic [AW-1:0]   r_mc;
    logic [15:0]     r_mp;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_b;

    logic signed [RW-1:0] w_abs;
    logic [DW:0]          w_trial;
    logic [DW:0]          w_diff;
    logic                 w_ge;
    logic [AW:0]          w_adj;
    logic signed [RW-1:0] w_ext;
    logic [CNTW-1:0]      w_lim;

    assign w_abs   = i_a[RW-1] ? -i_a : i_a;
    assign w_trial = {r_rem, r_q[AW-1]};
    assign w_diff  = w_trial - {1'b0, r_b};
    assign w_ge    = w_trial >= {1'b0, r_b};
    assign w_lim   = r_mul ? MUL_STEPS : DIV_STEPS;
    assign o_done  = r_busy && (r_cnt == w_lim);

    // Round the magnitude away from zero when the signs call for it, then restore the sign.
    assign w_adj = {1'b0, r_q} + (AW+1)'((r_rem != '0) && (r_neg != r_ceil));
    assign w_ext = {{(RW-AW-1){1'b0}}, w_adj};
    assign o_res = r_neg ? -w_ext : w_ext;
    assign o_rem = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_go) begin
                r_mul  <= i_mul;
                r_ceil <= i_ceil;
                r_neg  <= i_a[RW-1];
                r_b    <= i_b;
                r_rem  <= '0;
                r_mp   <= i_b[15:0];
                r_mc   <= w_abs[AW-1:0];
                r_q    <= i_mul ? '0 : w_abs[AW-1:0];
            end
        end else if (!o_done) begin
            if (r_mul) begin
                if (r_mp[0]) begin
                    r_q <= r_q + r_mc;
                end
                r_mc <= {r_mc[AW-2:0], 1'b0};
                r_mp <= {1'b0, r_mp[15:1]};
            end else begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_q   <= {r_q[AW-2:0], w_ge};
            end
        end
    end

endmodule

@@ rtl/nnrs_datapath.sv @@
// Datapath: configuration registers, row and column arithmetic, pending and output registers.
module nnrs_datapath import nnrs_pkg::*; #(
    parameter int MAX_DST_COLS = MAX_DST_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [15:0] i_source_row,
    input  logic [15:0] i_source_col,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_null_in,
    input  logic        i_has_null,
    input  logic        i_row_last,
    input  logic        i_out_stall,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_out_valid,
    output logic [15:0] o_screen_x,
    output logic [15:0] o_screen_y,
    output logic [15:0] o_line_count,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_null_out,
    output logic        o_null_valid,
    output logic        o_row_skipped,
    output logic        o_run_last,
    output logic [15:0] o_next_source_row
);

    localparam int CW = $clog2(MAX_DST_COLS + 1);

    logic [15:0] r_scs, r_sce, r_srs, r_sre, r_dcs, r_dce, r_drs, r_dre;

    logic [15:0] r_row, r_scol;
    logic [7:0]  r_red, r_green, r_blue, r_null;
    logic        r_hn, r_last;

    logic signed [33:0]   r_p;
    logic signed [RW-1:0] r_k0, r_k1, r_prod, r_tq;
    logic [15:0]          r_c0_q, r_ci_q, r_ci_r;
    logic [DW-1:0]        r_c0_r;
    logic [15:0]          r_top, r_height, r_next;

    logic [CW-1:0] r_col;
    logic [17:0]   r_src;
    logic [DW-1:0] r_crem;

    logic        r_pv;
    logic [15:0] r_px;
    logic [7:0]  r_pr, r_pg, r_pb, r_pn;
    logic        r_pnv;

    logic        r_ov;
    logic [15:0] r_ox, r_oy, r_ocnt, r_onext;
    logic [7:0]  r_or, r_og, r_ob, r_on;
    logic        r_onv, r_oskip, r_olast;

    logic signed [16:0]   w_sw, w_dw, w_sh, w_dh, w_rd;
    logic                 w_cols_ok, w_rows_ok;
    logic [CW-1:0]        w_ncols;
    logic signed [33:0]   w_prod;
    logic signed [RW-1:0] w_n0, w_n1;
    logic signed [RW-1:0] w_a;
    logic [DW-1:0]        w_b;
    logic                 w_mul, w_ceil, w_go;
    logic                 w_done;
    logic signed [RW-1:0] w_res;
    logic [DW-1:0]        w_rem;
    logic signed [RW-1:0] w_h, w_t, w_rp1x, w_m, w_nr;
    logic [16:0]          w_rp1;
    logic [17:0]          w_sum, w_twodw;
    logic                 w_wrap;
    logic                 w_out_free, w_load_pend;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scs <= 16'd0;
            r_sce <= 16'd1;
            r_srs <= 16'd0;
            r_sre <= 16'd1;
            r_dcs <= 16'd0;
            r_dce <= 16'd1;
            r_drs <= 16'd0;
            r_dre <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SRC_COL_START: r_scs <= i_cfg_data;
                CFG_SRC_COL_END:   r_sce <= i_cfg_data;
                CFG_SRC_ROW_START: r_srs <= i_cfg_data;
                CFG_SRC_ROW_END:   r_sre <= i_cfg_data;
                CFG_DST_COL_START: r_dcs <= i_cfg_data;
                CFG_DST_COL_END:   r_dce <= i_cfg_data;
                CFG_DST_ROW_START: r_drs <= i_cfg_data;
                CFG_DST_ROW_END:   r_dre <= i_cfg_data;
                default:           r_scs <= r_scs;
            endcase
        end
    end

    assign w_sw = $signed({1'b0, r_sce}) - $signed({1'b0, r_scs});
    assign w_dw = $signed({r_dce[15], r_dce}) - $signed({r_dcs[15], r_dcs});
    assign w_sh = $signed({1'b0, r_sre}) - $signed({1'b0, r_srs});
    assign w_dh = $signed({r_dre[15], r_dre}) - $signed({r_drs[15], r_drs});
    assign w_rd = $signed({1'b0, r_row}) - $signed({1'b0, r_srs});

    assign w_cols_ok = (w_sw > 17'sd0) && (w_dw > 17'sd0);
    assign w_rows_ok = (w_sh > 17'sd0) && (w_dh > 17'sd0);

    always_comb begin
        if (!w_cols_ok) begin
            w_ncols = '0;
        end else if (w_dw > $signed(17'(MAX_DST_COLS))) begin
            w_ncols = CW'(MAX_DST_COLS);
        end else begin
            w_ncols = CW'(w_dw[15:0]);
        end
    end

    // ---------------- input item ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            if (i_cmd.new_row) begin
                r_row <= i_source_row;
            end
            r_scol  <= i_source_col;
            r_red   <= i_red_in;
            r_green <= i_green_in;
            r_blue  <= i_blue_in;
            r_null  <= i_has_null ? i_null_in : 8'd0;
            r_hn    <= i_has_null;
            r_last  <= i_row_last;
        end
    end

    // ---------------- row mapping arithmetic ----------------
    assign w_prod = w_rd * w_dh;
    // Numerators of the forward map at the top and bottom edges of the row.
    assign w_n0 = {{(RW-35){r_p[33]}}, r_p, 1'b0} + sx17(w_sh);
    assign w_n1 = w_n0 + sx17(w_dh) + sx17(w_dh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_row) begin
            r_p <= w_prod;
        end
    end

    always_comb begin
        w_mul  = 1'b0;
        w_ceil = 1'b0;
        w_a    = '0;
        w_b    = '0;
        unique case (i_cmd.op)
            OP_K0: begin
                w_a = w_n0;
                w_b = {w_sh[15:0], 1'b0};
            end
            OP_K1: begin
                w_a = w_n1;
                w_b = {w_sh[15:0], 1'b0};
            end
            OP_MULT: begin
                w_mul = 1'b1;
                w_a   = {r_k1[RW-2:0], 1'b1};
                w_b   = {1'b0, w_sh[15:0]};
            end
            OP_TDIV: begin
                w_ceil = 1'b1;
                w_a    = r_prod;
                w_b    = {w_dh[15:0], 1'b0};
            end
            OP_C0: begin
                w_a = sx17(w_sw);
                w_b = {w_dw[15:0], 1'b0};
            end
            OP_CI: begin
                w_a = sx17(w_sw);
                w_b = {1'b0, w_dw[15:0]};
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    assign w_go = i_cmd.arith_go;

    nnrs_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_mul   (w_mul),
        .i_ceil  (w_ceil),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            case (i_cmd.op)
                OP_K0:   r_k0   <= w_res;
                OP_K1:   r_k1   <= w_res;
                OP_MULT: r_prod <= w_res;
                OP_TDIV: r_tq   <= w_res;
                OP_C0: begin
                    r_c0_q <= w_res[15:0];
                    r_c0_r <= w_rem;
                end
                OP_CI: begin
                    r_ci_q <= w_res[15:0];
                    r_ci_r <= w_rem[15:0];
                end
                default: r_k0 <= r_k0;
            endcase
        end
    end

    assign w_h    = r_k1 - r_k0;
    assign w_t    = {{(RW-16){1'b0}}, r_srs} + r_tq;
    assign w_rp1  = {1'b0, r_row} + 17'd1;
    assign w_rp1x = {{(RW-17){1'b0}}, w_rp1};
    assign w_m    = (w_t > w_rp1x) ? w_t : w_rp1x;
    assign w_nr   = w_m - RW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_fin) begin
            if (w_rows_ok) begin
                r_top <= r_drs + r_k0[15:0];
                if (w_h <= RW'(0)) begin
                    r_height <= 16'd0;
                end else if (w_h > RW'(65535)) begin
                    r_height <= 16'hffff;
                end else begin
                    r_height <= w_h[15:0];
                end
                r_next <= (w_nr > RW'(65535)) ? 16'hffff : w_nr[15:0];
            end else begin
                r_top    <= r_drs;
                r_height <= 16'd0;
                r_next   <= w_rp1[16] ? 16'hffff : w_rp1[15:0];
            end
        end
    end

    // ---------------- column walk ----------------
    assign w_sum   = {1'b0, r_crem} + {1'b0, r_ci_r, 1'b0};
    assign w_twodw = {1'b0, w_dw[15:0], 1'b0};
    assign w_wrap  = w_sum >= w_twodw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_init) begin
            r_col <= '0;
            if (w_cols_ok) begin
                r_src  <= {2'b00, r_scs} + {2'b00, r_c0_q};
                r_crem <= r_c0_r;
            end else begin
                r_src  <= '0;
                r_crem <= '0;
            end
        end else if (i_cmd.advance) begin
            r_col  <= r_col + 1'b1;
            r_crem <= w_wrap ? 17'(w_sum - w_twodw) : w_sum[DW-1:0];
            r_src  <= r_src + {2'b00, r_ci_q} + 18'(w_wrap);
        end
    end

    // ---------------- pending and output registers ----------------
    assign w_out_free  = !r_ov || !i_out_stall;
    assign w_load_pend = (i_cmd.push && r_pv) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_cmd.push) begin
            r_pv <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_px  <= r_dcs + 16'(r_col);
            r_pr  <= r_red;
            r_pg  <= r_green;
            r_pb  <= r_blue;
            r_pn  <= r_null;
            r_pnv <= r_hn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_pend || i_cmd.special) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_pend) begin
            r_ox    <= r_px;
            r_oy    <= r_top;
            r_ocnt  <= r_height;
            r_or    <= r_pr;
            r_og    <= r_pg;
            r_ob    <= r_pb;
            r_on    <= r_pn;
            r_onv   <= r_pnv;
            r_oskip <= 1'b0;
            r_olast <= i_cmd.flush && r_last;
            r_onext <= (i_cmd.flush && r_last) ? r_next : 16'd0;
        end else if (i_cmd.special) begin
            r_ox    <= 16'd0;
            r_oy    <= r_top;
            r_ocnt  <= 16'd0;
            r_or    <= 8'd0;
            r_og    <= 8'd0;
            r_ob    <= 8'd0;
            r_on    <= 8'd0;
            r_onv   <= 1'b0;
            r_oskip <= (r_height == 16'd0);
            r_olast <= 1'b1;
            r_onext <= r_next;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_screen_x        = r_ox;
    assign o_screen_y        = r_oy;
    assign o_line_count      = r_ocnt;
    assign o_red_out         = r_or;
    assign o_green_out       = r_og;
    assign o_blue_out        = r_ob;
    assign o_null_out        = r_on;
    assign o_null_valid      = r_onv;
    assign o_row_skipped     = r_oskip;
    assign o_run_last        = r_olast;
    assign o_next_source_row = r_onext;

    assign o_status.arith_done = w_done;
    assign o_status.rows_ok    = w_rows_ok;
    assign o_status.cols_ok    = w_cols_ok;
    assign o_status.col_lt     = r_col < w_ncols;
    assign o_status.src_lt     = r_src < {2'b00, r_scol};
    assign o_status.src_eq     = r_src == {2'b00, r_scol};
    assign o_status.height_nz  = r_height != 16'd0;
    assign o_status.pend_valid = r_pv;
    assign o_status.out_free   = w_out_free;
    assign o_status.last       = r_last;

endmodule

@@ rtl/nnrs_ctrl.sv @@
// Controller: sequences row setup, the column walk of each pixel and the row end.
module nnrs_ctrl import nnrs_pkg::*; #(
    parameter int MAX_ZOOM = MAX_ZOOM_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int ZW = $clog2(MAX_ZOOM + 1);

    t_state        r_state, n_state;
    logic          r_row_open, n_row_open;
    logic [ZW-1:0] r_zoom, n_zoom;

    logic w_accept, w_match, w_room;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_match    = i_status.col_lt && i_status.src_eq;
    assign w_room     = i_status.height_nz && (r_zoom < ZW'(MAX_ZOOM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row_open <= 1'b0;
            r_zoom     <= '0;
        end else begin
            r_state    <= n_state;
            r_row_open <= n_row_open;
            r_zoom     <= n_zoom;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_row_open) begin
                        n_state = S_SKIP;
                    end else if (i_status.rows_ok) begin
                        n_state = S_R_MUL;
                    end else begin
                        n_state = S_R_FIN;
                    end
                end
            end
            S_R_MUL: n_state = S_K0;
            S_K0:    if (i_status.arith_done) n_state = S_K1;
            S_K1:    if (i_status.arith_done) n_state = S_MULT;
            S_MULT:  if (i_status.arith_done) n_state = S_TDIV;
            S_TDIV:  if (i_status.arith_done) n_state = S_R_FIN;
            S_R_FIN: n_state = i_status.cols_ok ? S_C0 : S_C_INIT;
            S_C0:    if (i_status.arith_done) n_state = S_CI;
            S_CI:    if (i_status.arith_done) n_state = S_C_INIT;
            S_C_INIT: n_state = S_SKIP;
            S_SKIP: begin
                if (!(i_status.col_lt && i_status.src_lt)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!w_match) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (i_status.pend_valid || i_status.last) begin
                    if (i_status.out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and counters.
    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_K0;
        n_row_open = r_row_open;
        n_zoom     = r_zoom;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.new_row = !r_row_open;
                    n_zoom        = '0;
                end
            end
            S_R_MUL: o_cmd.mul_row = 1'b1;
            S_K0: begin
                o_cmd.arith_go = 1'b1;
                o_cmd.op       = OP_K0;
            end
            S_K1: begin
                o_cmd.arith_go = 1'b1;
                o_cmd.op       = OP_K1;
            end
            S_MULT: begin
                o_cmd.arith_go = 1'b1;
                o_cmd.op       = OP_MULT;
            end
            S_TDIV: begin
                o_cmd.arith_go = 1'b1;
                o_cmd.op       = OP_TDIV;
            end
            S_R_FIN: o_cmd.row_fin = 1'b1;
            S_C0: begin
                o_cmd.arith_go = 1'b1;
                o_cmd.op       = OP_C0;
            end
            S_CI: begin
                o_cmd.arith_go = 1'b1;
                o_cmd.op       = OP_CI;
            end
            S_C_INIT: begin
                o_cmd.col_init = 1'b1;
                n_row_open     = 1'b1;
            end
            S_SKIP: begin
                o_cmd.advance = i_status.col_lt && i_status.src_lt;
            end
            S_EMIT: begin
                if (w_match) begin
                    if (w_room) begin
                        // A held pixel must move out before a new one takes its place.
                        if (!i_status.pend_valid || i_status.out_free) begin
                            o_cmd.push    = 1'b1;
                            o_cmd.advance = 1'b1;
                            n_zoom        = r_zoom + 1'b1;
                        end
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    if (i_status.pend_valid) begin
                        o_cmd.flush = 1'b1;
                    end else if (i_status.last) begin
                        o_cmd.special = 1'b1;
                    end
                end
                if (i_status.last && (n_state == S_IDLE)) begin
                    n_row_open = 1'b0;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/nearest_neighbor_row_scaler.sv @@
// Top level of the nearest-neighbor row scaler.
// The block takes the source pixels of one raster row in column order and emits, for each
// pixel, every screen column that maps onto it, tagged with the row's top screen line and
// the number of screen lines it covers; the last result of a row carries the next source
// row worth sending, and a row that covers no screen line gives a single skip result.
// The first pixel of a row starts a row setup that runs five divisions and one
// multiplication one after the other on a single serial arithmetic unit. With a
// degenerate row region the four row operations are left out; with a degenerate
// column region the two column divisions are left out. After that the pixel walks
// the screen columns, passing each over or emitting it, and may wait for the output
// register to be taken. Inputs are accepted only between pixels; the output register
// and a one-deep hold register let the next pixel start while a result waits to be taken.
// Results are copies of source pixels; at most MAX_ZOOM screen columns are emitted per
// pixel and the screen width is cut to MAX_DST_COLS. Configuration writes are always
// ready and must only be done while no pixel is in flight.
module nearest_neighbor_row_scaler import nnrs_pkg::*; #(
    parameter int MAX_DST_COLS = MAX_DST_COLS_DEF,
    parameter int MAX_ZOOM     = MAX_ZOOM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Source pixel channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_source_row,
    input  logic [15:0] i_source_col,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_null_in,
    input  logic        i_has_null,
    input  logic        i_row_last,
    // Screen pixel channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_screen_x,
    output logic [15:0] o_screen_y,
    output logic [15:0] o_line_count,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_null_out,
    output logic        o_null_valid,
    output logic        o_row_skipped,
    output logic        o_run_last,
    output logic [15:0] o_next_source_row
);

    t_cmd    w_cmd;
    t_status w_status;

    // Register writes complete in the cycle they are offered.
    assign o_cfg_ready = 1'b1;

    // The controller decides what happens to each transfer; the datapath holds all numbers.
    nnrs_ctrl #(
        .MAX_ZOOM (MAX_ZOOM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    nnrs_datapath #(
        .MAX_DST_COLS (MAX_DST_COLS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_source_row      (i_source_row),
        .i_source_col      (i_source_col),
        .i_red_in          (i_red_in),
        .i_green_in        (i_green_in),
        .i_blue_in         (i_blue_in),
        .i_null_in         (i_null_in),
        .i_has_null        (i_has_null),
        .i_row_last        (i_row_last),
        .i_out_stall       (i_out_stall),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .o_screen_x        (o_screen_x),
        .o_screen_y        (o_screen_y),
        .o_line_count      (o_line_count),
        .o_red_out         (o_red_out),
        .o_green_out       (o_green_out),
        .o_blue_out        (o_blue_out),
        .o_null_out        (o_null_out),
        .o_null_valid      (o_null_valid),
        .o_row_skipped     (o_row_skipped),
        .o_run_last        (o_run_last),
        .o_next_source_row (o_next_source_row)
    );

endmodule

@@ rtl/nnrs_checker.sv @@
// Port-level checker of the nearest-neighbor row scaler and its bind statement.
`include "nearest_neighbor_row_scaler_macros.svh"

module nnrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_screen_x,
    input logic [15:0] o_line_count,
    input logic        o_row_skipped,
    input logic        o_run_last,
    input logic [15:0] o_next_source_row
);

    `NNRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "stalled result dropped")
    `NNRS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_screen_x) && $stable(o_run_last), "stalled result changed")
    `NNRS_ASSERT_SAME(a_skip_shape, i_clk, i_rst_n, o_out_valid && o_row_skipped, o_run_last && (o_line_count == 16'd0) && (o_screen_x == 16'd0), "malformed skip result")
    `NNRS_ASSERT_SAME(a_next_only_last, i_clk, i_rst_n, o_out_valid && !o_run_last, o_next_source_row == 16'd0, "next row shown before row end")

endmodule

bind nearest_neighbor_row_scaler nnrs_checker u_nnrs_checker (.*);
